// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CPC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define CPC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Types, character constants and helpers for the percent-escape codec.
// ----------------------------------------------------------------------------
package cpc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RAW      = 3'd1,
        ST_HEX      = 3'd2,
        ST_NEEDLESS = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    // One decoded or encoded result held for the output side
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        status_t    status;
        logic       tend;
        logic       esc;
    } result_t;

    localparam logic [7:0] PLAIN_LO = 8'h21;
    localparam logic [7:0] PLAIN_HI = 8'h7E;
    localparam logic [7:0] ESC_CHAR = 8'h25;
    localparam logic [7:0] DIGIT_0  = 8'h30;
    localparam logic [7:0] DIGIT_9  = 8'h39;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_F  = 8'h46;

    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_HIGH  = 2'd1;
    localparam logic [1:0] BEAT_LAST  = 2'd2;

    localparam logic       REG_DIRECTION = 1'b0;
    localparam logic       DIR_ENCODE    = 1'b0;
    localparam logic       DIR_DECODE    = 1'b1;

    function automatic logic is_plain(input logic [7:0] b);
        return (b >= PLAIN_LO) && (b <= PLAIN_HI) && (b != ESC_CHAR);
    endfunction

    function automatic logic hex_ok(input logic [7:0] b);
        return ((b >= DIGIT_0) && (b <= DIGIT_9)) || ((b >= UPPER_A) && (b <= UPPER_F));
    endfunction

    // Valid only when hex_ok holds
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        return (b <= DIGIT_9) ? b[3:0] : (b[3:0] + 4'd9);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (DIGIT_0 + {4'd0, n}) : (UPPER_A + {4'd0, n} - 8'd10);
    endfunction

endpackage

// ===== rtl/core/canonical_percent_codec.sv =====
// Output: the first result of an item is registered and offered in the cycle after acceptance.
// Throughput: one item per cycle while items give at most one result and out_stall is low;
// an encoded escape holds the input until its three output bytes leave the result register.
// Items that give no result (escape prefix, swallowed bytes) leave the result register empty.
// Reset: direction set to decode, escape phase, nibble and token error cleared, output empty.
// ----------------------------------------------------------------------------
// canonical_percent_codec
// Canonical upper-case percent-escape encoder/decoder for tokenised byte streams.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module canonical_percent_codec
    import cpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,

    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        run_last,
    output logic        token_end,
    output logic [2:0]  status
);

    // ------------------------------------------------------------------
    // Configuration: one register, direction, at word 0. Any write to the
    // upper word is dropped; reads of it return zero.
    // ------------------------------------------------------------------
    logic direction_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_DECODE;
        end
        else if (cfg_write && (paddr[2] == REG_DIRECTION))
        begin
            direction_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Token state
    // ------------------------------------------------------------------
    phase_t     phase_reg,  phase_next;
    logic [3:0] nibble_reg, nibble_next;
    status_t    error_reg,  error_next;

    // Result register and beat counter for the three-byte escape
    result_t    result_reg, result_next;
    logic       valid_reg;
    logic [1:0] beat_reg;

    logic       emit;
    logic       in_accept;
    logic       out_take;
    logic       last_beat;

    // Byte classification of the incoming item
    logic       byte_plain;
    logic       byte_hex;
    logic [7:0] pair_value;
    logic       pair_plain;

    assign byte_plain = is_plain(in_byte);
    assign byte_hex   = hex_ok(in_byte);
    assign pair_value = {nibble_reg, hex_val(in_byte)};
    assign pair_plain = is_plain(pair_value);

    // ------------------------------------------------------------------
    // Handshake: take a new item when the result register is empty or
    // its final beat leaves this cycle.
    // ------------------------------------------------------------------
    assign last_beat = !result_reg.esc || (beat_reg == BEAT_LAST);
    assign out_take  = valid_reg && !out_stall;
    assign in_stall  = valid_reg && !(out_take && last_beat);
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Next token state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        error_next  = error_reg;

        if (direction_reg == DIR_ENCODE)
        begin
            // encode leaves the decoder clean
            phase_next  = PH_IDLE;
            nibble_next = 4'd0;
            error_next  = ST_OK;
        end
        else if (error_reg != ST_OK)
        begin
            // swallow until the token ends
            if (in_last)
            begin
                error_next = ST_OK;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == ESC_CHAR)
                    begin
                        if (!in_last)
                        begin
                            phase_next = PH_HIGH;
                        end
                    end
                    else if (!byte_plain && !in_last)
                    begin
                        error_next = ST_RAW;
                    end
                end
                PH_HIGH:
                begin
                    if (in_last)
                    begin
                        phase_next  = PH_IDLE;
                        nibble_next = 4'd0;
                    end
                    else if (!byte_hex)
                    begin
                        phase_next  = PH_IDLE;
                        nibble_next = 4'd0;
                        error_next  = ST_HEX;
                    end
                    else
                    begin
                        phase_next  = PH_LOW;
                        nibble_next = hex_val(in_byte);
                    end
                end
                default:
                begin
                    // low digit closes the escape whatever its outcome
                    phase_next  = PH_IDLE;
                    nibble_next = 4'd0;
                    if (!in_last)
                    begin
                        if (!byte_hex)
                        begin
                            error_next = ST_HEX;
                        end
                        else if (pair_plain)
                        begin
                            error_next = ST_NEEDLESS;
                        end
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result of the incoming item
    // ------------------------------------------------------------------
    always_comb
    begin
        emit               = 1'b0;
        result_next.data   = 8'd0;
        result_next.has    = 1'b0;
        result_next.status = ST_OK;
        result_next.tend   = 1'b1;
        result_next.esc    = 1'b0;

        if (direction_reg == DIR_ENCODE)
        begin
            emit             = 1'b1;
            result_next.data = in_byte;
            result_next.has  = 1'b1;
            result_next.tend = in_last;
            result_next.esc  = !byte_plain;
        end
        else if (error_reg != ST_OK)
        begin
            emit               = in_last;
            result_next.status = error_reg;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == ESC_CHAR)
                    begin
                        emit               = in_last;
                        result_next.status = ST_TRUNC;
                    end
                    else if (!byte_plain)
                    begin
                        emit               = in_last;
                        result_next.status = ST_RAW;
                    end
                    else
                    begin
                        emit             = 1'b1;
                        result_next.data = in_byte;
                        result_next.has  = 1'b1;
                        result_next.tend = in_last;
                    end
                end
                PH_HIGH:
                begin
                    // truncation wins over a bad high digit
                    emit               = in_last;
                    result_next.status = ST_TRUNC;
                end
                default:
                begin
                    if (!byte_hex)
                    begin
                        emit               = in_last;
                        result_next.status = ST_HEX;
                    end
                    else if (pair_plain)
                    begin
                        emit               = in_last;
                        result_next.status = ST_NEEDLESS;
                    end
                    else
                    begin
                        emit             = 1'b1;
                        result_next.data = pair_value;
                        result_next.has  = 1'b1;
                        result_next.tend = in_last;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            nibble_reg <= 4'd0;
            error_reg  <= ST_OK;
            valid_reg  <= 1'b0;
            beat_reg   <= BEAT_FIRST;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg  <= phase_next;
                nibble_reg <= nibble_next;
                error_reg  <= error_next;
            end

            if (in_accept && emit)
            begin
                valid_reg <= 1'b1;
                beat_reg  <= BEAT_FIRST;
            end
            else if (out_take && last_beat)
            begin
                valid_reg <= 1'b0;
            end
            else if (out_take)
            begin
                // advance through the escape bytes
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Output fields: plain results pass through, escapes expand to
    // '%', high digit, low digit.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_byte = result_reg.data;
        if (result_reg.esc)
        begin
            case (beat_reg)
                BEAT_FIRST: out_byte = ESC_CHAR;
                BEAT_HIGH:  out_byte = hex_digit(result_reg.data[7:4]);
                default:    out_byte = hex_digit(result_reg.data[3:0]);
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign has_byte  = result_reg.has;
    assign run_last  = last_beat;
    assign token_end = result_reg.tend && last_beat;
    assign status    = result_reg.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CPC_ASSERT_IMP(a_error_form, out_valid && (status != ST_OK), !has_byte && run_last && token_end)
    `CPC_ASSERT_NXT(a_escape_start, in_accept && (direction_reg == DIR_ENCODE) && !byte_plain, out_valid && !run_last && (out_byte == ESC_CHAR))
    `CPC_ASSERT_NXT(a_escape_cont, out_valid && !run_last && !out_stall, out_valid)
    `CPC_ASSERT_IMP(a_empty_ready, !out_valid, !in_stall)

endmodule

// ===== dv/tb_canonical_percent_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canonical_percent_codec
// Self-checking bench for the canonical percent-escape codec. A queue of
// tokens feeds a valid/stall driver. A monitor predicts the expected bytes
// for every item accepted and checks each result field by field. Directed
// tokens come first, then random well-formed and broken tokens, under
// several idle and stall mixes, in both directions.
// ----------------------------------------------------------------------------
module tb_canonical_percent_codec;
    import cpc_pkg::*;

    // Address map: direction is register 0; the next word is unused
    localparam logic [2:0] ADDR_DIRECTION = 3'd0;
    localparam logic [2:0] ADDR_SPARE     = 3'd4;
    localparam logic [7:0] PCT            = 8'h25;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         SETTLE_CYCLES  = 4;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } codec_input_t;

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       rlast;
        logic       tend;
        status_t    st;
    } codec_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        run_last;
    logic        token_end;
    logic [2:0]  status;

    // Items waiting for the driver, and results waiting for the output side
    codec_input_t  pending_bytes[$];
    codec_result_t expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued_items   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    // Predictor state: a mirror of the direction register and token tracking
    logic       dir_model;
    phase_t     esc_phase;
    logic [3:0] hi_nib;
    status_t    tok_err;

    canonical_percent_codec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .run_last  (run_last),
        .token_end (token_end),
        .status    (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Byte classes
    // ------------------------------------------------------------------------

    // A literal byte passes through unescaped in both directions
    function automatic logic is_literal(input logic [7:0] b);
        return (b >= 8'h21) && (b <= 8'h7E) && (b != PCT);
    endfunction

    // Upper-case hex digit value; bit 4 set flags anything else
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return {1'b0, 4'(b - 8'h30)};
        if (b >= "A" && b <= "F")
            return {1'b0, 4'(b - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_token_state();
        esc_phase = PH_IDLE;
        hi_nib    = 4'd0;
        tok_err   = ST_OK;
    endfunction

    function automatic void emit_result(input logic [7:0] d, input logic has,
                                        input logic rl, input logic te,
                                        input status_t st);
        codec_result_t r;
        r.data  = d;
        r.has   = has;
        r.rlast = rl;
        r.tend  = te;
        r.st    = st;
        expected_results = {expected_results, r};
    endfunction

    // Report at once on the last byte, else hold the error for the token's end
    function automatic void reject_token(input status_t code, input logic last);
        if (last)
        begin
            emit_result(8'h00, 1'b0, 1'b1, 1'b1, code);
            clear_token_state();
        end
        else
        begin
            tok_err   = code;
            esc_phase = PH_IDLE;
            hi_nib    = 4'd0;
        end
    endfunction

    function automatic void predict_codec_results(input logic [7:0] b, input logic last);
        logic [4:0] v;
        logic [7:0] full;
        if (dir_model == DIR_ENCODE)
        begin
            clear_token_state();
            if (is_literal(b))
                emit_result(b, 1'b1, 1'b1, last, ST_OK);
            else
            begin
                emit_result(PCT, 1'b1, 1'b0, 1'b0, ST_OK);
                emit_result(hex_char(b[7:4]), 1'b1, 1'b0, 1'b0, ST_OK);
                emit_result(hex_char(b[3:0]), 1'b1, 1'b1, last, ST_OK);
            end
            return;
        end
        // Swallow the rest of a token that has already failed
        if (tok_err != ST_OK)
        begin
            if (last)
            begin
                emit_result(8'h00, 1'b0, 1'b1, 1'b1, tok_err);
                clear_token_state();
            end
            return;
        end
        case (esc_phase)
            PH_IDLE:
            begin
                if (b == PCT)
                begin
                    if (last)
                        reject_token(ST_TRUNC, 1'b1);
                    else
                        esc_phase = PH_HIGH;
                end
                else if (!is_literal(b))
                    reject_token(ST_RAW, last);
                else
                begin
                    emit_result(b, 1'b1, 1'b1, last, ST_OK);
                    if (last)
                        clear_token_state();
                end
            end
            PH_HIGH:
            begin
                // Truncation wins over a bad high digit
                v = hex_value(b);
                if (last)
                    reject_token(ST_TRUNC, 1'b1);
                else if (v[4])
                    reject_token(ST_HEX, 1'b0);
                else
                begin
                    hi_nib    = v[3:0];
                    esc_phase = PH_LOW;
                end
            end
            default:
            begin
                v = hex_value(b);
                full = {hi_nib, v[3:0]};
                if (v[4])
                    reject_token(ST_HEX, last);
                else if (is_literal(full))
                    reject_token(ST_NEEDLESS, last);
                else
                begin
                    esc_phase = PH_IDLE;
                    hi_nib    = 4'd0;
                    emit_result(full, 1'b1, 1'b1, last, ST_OK);
                    if (last)
                        clear_token_state();
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next queued item once the current one has gone
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_byte  <= pending_bytes[0].data;
                in_last  <= pending_bytes[0].last;
                void'(pending_bytes.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the result leaving this edge, then predict for the item
    // accepted at it. A result can never stem from an item taken at the same
    // edge, so checking first keeps the order sound.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        codec_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual byte %0h status %0d",
                             $time, out_byte, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_byte", want.data, out_byte);
                    check_field("has_byte", want.has, has_byte);
                    check_field("run_last", want.rlast, run_last);
                    check_field("token_end", want.tend, token_end);
                    check_field("status", int'(want.st), status);
                end
            end
            if (in_valid && !in_stall)
                predict_codec_results(in_byte, in_last);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input logic last);
        codec_input_t it;
        it.data = b;
        it.last = last;
        pending_bytes = {pending_bytes, it};
        queued_items++;
    endtask

    task automatic add_token(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            add_item(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic logic [7:0] pick_literal();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h21, 8'h7E)); while (b == PCT);
        return b;
    endfunction

    function automatic logic [7:0] pick_escaped();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (is_literal(b));
        return b;
    endfunction

    // Mostly well-formed escaped text; about a third carries one defect
    task automatic add_decode_token();
        logic [7:0] tok_bytes[$];
        logic [7:0] b;
        int units;
        int pos;
        units = $urandom_range(1, 6);
        for (int i = 0; i < units; i++)
        begin
            if ($urandom_range(1))
                tok_bytes = {tok_bytes, pick_literal()};
            else
            begin
                b = pick_escaped();
                tok_bytes = {tok_bytes, PCT, hex_char(b[7:4]), hex_char(b[3:0])};
            end
        end
        if ($urandom_range(99) < 35)
        begin
            pos = $urandom_range(tok_bytes.size());
            case ($urandom_range(5))
                0:  tok_bytes[$urandom_range(tok_bytes.size() - 1)] = 8'($urandom_range(255));
                1:
                begin
                    // lower-case digit in either place of an escape
                    b = 8'($urandom_range("a", "f"));
                    if ($urandom_range(1))
                    begin
                        tok_bytes.insert(pos, hex_char(4'($urandom_range(15))));
                        tok_bytes.insert(pos, b);
                    end
                    else
                    begin
                        tok_bytes.insert(pos, b);
                        tok_bytes.insert(pos, hex_char(4'($urandom_range(15))));
                    end
                    tok_bytes.insert(pos, PCT);
                end
                2:
                begin
                    // escape cut off at the end, high digit possibly bogus
                    tok_bytes = {tok_bytes, PCT};
                    if ($urandom_range(1))
                        tok_bytes = {tok_bytes, 8'($urandom_range(255))};
                end
                3:
                begin
                    b = pick_literal();
                    tok_bytes.insert(pos, hex_char(b[3:0]));
                    tok_bytes.insert(pos, hex_char(b[7:4]));
                    tok_bytes.insert(pos, PCT);
                end
                4:  tok_bytes.insert(pos, pick_escaped());
                default:
                begin
                    // pure noise
                    tok_bytes.delete();
                    for (int i = 0; i < $urandom_range(1, 5); i++)
                        tok_bytes = {tok_bytes, 8'($urandom_range(255))};
                end
            endcase
        end
        add_token(tok_bytes);
    endtask

    task automatic add_encode_token();
        logic [7:0] tok_bytes[$];
        for (int i = 0; i < $urandom_range(1, 6); i++)
            tok_bytes = {tok_bytes, 8'($urandom_range(255))};
        add_token(tok_bytes);
    endtask

    task automatic add_random_tokens(input logic dir, input int n);
        int start;
        start = queued_items;
        while (queued_items - start < n)
        begin
            if (dir == DIR_DECODE)
                add_decode_token();
            else
                add_encode_token();
        end
    endtask

    // Hold until the sender is empty and every result has arrived, then let
    // a swallowed item finish its cycle
    task automatic wait_for_quiet();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DIRECTION)
            dir_model = data[0];
    endtask

    // Read a register and compare it with the expected value
    task automatic read_config(input logic [2:0] addr, input logic [31:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("prdata", int'(want), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_mix[4];
        int stall_mix[4];
        idle_mix  = '{0, 87, 0, 19};
        stall_mix = '{0, 0, 87, 19};
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_DIRECTION;
        pwdata  = 32'd0;
        dir_model = DIR_DECODE;
        clear_token_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Unused word must be ignored; direction written explicitly once
        write_config(ADDR_SPARE, $urandom);
        read_config(ADDR_SPARE, 32'd0);
        read_config(ADDR_DIRECTION, {31'd0, DIR_DECODE});
        write_config(ADDR_DIRECTION, {31'd0, DIR_DECODE});

        // Decode: plain, needless escape, top escape, bare '%', truncation on
        // a bogus high digit, raw byte swallowing the rest, lower-case digit,
        // raw zero on the last byte
        add_token('{8'h21});
        add_token('{PCT, "4", "1"});
        add_token('{PCT, "F", "F"});
        add_token('{PCT});
        add_token('{PCT, "g"});
        add_token('{8'h20, "B"});
        add_token('{PCT, "2", "a"});
        add_token('{8'h00});
        wait_for_quiet();

        // Encode: both byte extremes, plain edges, the escape character itself
        write_config(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
        read_config(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
        add_token('{8'h00, 8'h7E, PCT, 8'h21, 8'hFF});
        wait_for_quiet();

        // Direction switches inside open tokens
        add_item("A", 1'b0);
        wait_for_quiet();
        write_config(ADDR_DIRECTION, {31'd0, DIR_DECODE});
        add_token('{PCT, "4"});
        pending_bytes[pending_bytes.size() - 1].last = 1'b0;
        wait_for_quiet();
        write_config(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
        add_item(8'h0A, 1'b1);
        wait_for_quiet();
        write_config(ADDR_DIRECTION, {31'd0, DIR_DECODE});
        add_item(8'h20, 1'b0);
        wait_for_quiet();
        write_config(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
        add_item("Z", 1'b1);
        wait_for_quiet();
        write_config(ADDR_DIRECTION, {31'd0, DIR_DECODE});
        add_item("Q", 1'b1);
        wait_for_quiet();

        // Random tokens under each idle/stall mix, both directions
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            write_config(ADDR_DIRECTION, {31'd0, DIR_DECODE});
            add_random_tokens(DIR_DECODE, 52);
            wait_for_quiet();
            write_config(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
            add_random_tokens(DIR_ENCODE, 28);
            wait_for_quiet();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cpc_pkg.sv
rtl/core/canonical_percent_codec.sv
dv/tb_canonical_percent_codec.sv
